>>> rtl/core/h264nal_pkg.sv
// Shared types and constants for the H.264 Annex B unit splitter.
`timescale 1ns / 1ps
`default_nettype none

package h264nal_pkg;

  localparam int SIZE_BITS_DEF = 16;
  localparam int OUT_SIZE_BITS = 16;
  localparam int FIFO_DEPTH = 4;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_EOS  = 1'b1;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_LAST = 2'd1;
  localparam logic [1:0] STATUS_ERR  = 2'd2;

  localparam logic [4:0] TYPE_IDR = 5'd5;
  localparam logic [4:0] TYPE_SPS = 5'd7;
  localparam logic [4:0] TYPE_PPS = 5'd8;
  localparam logic [4:0] TYPE_NONE = 5'd0;
  localparam logic [1:0] REF_FORCED = 2'd3;

  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONE  = 8'h01;

  // Snapshot of a finished unit, handed from the scanner to the formatter.
  typedef struct packed {
    logic       no_start;
    logic       last;
    logic       overflow;
    logic       payload_seen;
    logic [6:0] header_bits;
  } unit_info_t;

  localparam int INFO_W = $bits(unit_info_t);

endpackage

`default_nettype wire

>>> rtl/core/h264nal_if.sv
// Valid/ready channel interfaces for stream bytes and unit descriptors.
`timescale 1ns / 1ps
`default_nettype none

interface h264nal_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink (input valid, input kind, input data_byte, output ready);
endinterface

interface h264nal_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] unit_size;
  logic [4:0]  nal_type;
  logic [1:0]  ref_level;
  logic        type_invalid;
  logic [1:0]  status;
  logic        size_saturated;

  modport source (output valid, output unit_size, output nal_type, output ref_level,
                  output type_invalid, output status, output size_saturated,
                  input ready);
  modport sink (input valid, input unit_size, input nal_type, input ref_level,
                input type_invalid, input status, input size_saturated,
                output ready);
endinterface

`default_nettype wire

>>> rtl/core/h264nal_front.sv
// Byte scanner: tracks start codes, unit length and header, pushes finished units.
`timescale 1ns / 1ps
`default_nettype none

module h264nal_front #(
  parameter int SIZE_BITS = h264nal_pkg::SIZE_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  h264nal_in_if.sink                     in_ch,
  input  wire logic                      fifo_full,
  output logic                           push,
  output h264nal_pkg::unit_info_t        push_info,
  output logic [SIZE_BITS-1:0]           push_count,
  output logic [SIZE_BITS-1:0]           push_zeros
);

  localparam logic [SIZE_BITS-1:0] CNT_MAX = '1;
  localparam logic [SIZE_BITS-1:0] CNT_ONE = SIZE_BITS'(1);
  localparam logic [SIZE_BITS-1:0] CNT_TWO = SIZE_BITS'(2);

  logic [SIZE_BITS-1:0] unit_count_r, unit_count_nxt;
  logic [SIZE_BITS-1:0] zero_run_r, zero_run_nxt;
  logic                 start_seen_r, start_seen_nxt;
  logic                 header_pending_r, header_pending_nxt;
  logic [6:0]           header_bits_r, header_bits_nxt;
  logic                 payload_seen_r, payload_seen_nxt;
  logic                 overflow_r, overflow_nxt;

  logic fire;
  logic is_start;

  assign in_ch.ready = !fifo_full;
  assign fire = in_ch.valid && !fifo_full;
  assign is_start = (in_ch.data_byte == h264nal_pkg::BYTE_ONE) && (zero_run_r >= CNT_TWO);

  assign push_count = unit_count_r;
  assign push_zeros = zero_run_r;

  always_comb begin
    unit_count_nxt     = unit_count_r;
    zero_run_nxt       = zero_run_r;
    start_seen_nxt     = start_seen_r;
    header_pending_nxt = header_pending_r;
    header_bits_nxt    = header_bits_r;
    payload_seen_nxt   = payload_seen_r;
    overflow_nxt       = overflow_r;
    push               = 1'b0;
    push_info.no_start     = !start_seen_r;
    push_info.last         = 1'b0;
    push_info.overflow     = overflow_r;
    push_info.payload_seen = payload_seen_r;
    push_info.header_bits  = header_bits_r;

    if (fire) begin
      if (in_ch.kind == h264nal_pkg::KIND_EOS) begin
        push               = 1'b1;
        push_info.last     = 1'b1;
        unit_count_nxt     = '0;
        zero_run_nxt       = '0;
        start_seen_nxt     = 1'b0;
        header_pending_nxt = 1'b0;
        header_bits_nxt    = '0;
        payload_seen_nxt   = 1'b0;
        overflow_nxt       = 1'b0;
      end else if (is_start) begin
        push = start_seen_r;
        if (zero_run_r == CNT_MAX) begin
          unit_count_nxt = CNT_MAX;
          overflow_nxt   = 1'b1;
        end else begin
          unit_count_nxt = zero_run_r + CNT_ONE;
          overflow_nxt   = 1'b0;
        end
        start_seen_nxt     = 1'b1;
        header_pending_nxt = 1'b1;
        header_bits_nxt    = '0;
        payload_seen_nxt   = 1'b0;
        zero_run_nxt       = '0;
      end else begin
        if (start_seen_r) begin
          if (unit_count_r != CNT_MAX) begin
            unit_count_nxt = unit_count_r + CNT_ONE;
          end else begin
            overflow_nxt = 1'b1;
          end
          if (header_pending_r) begin
            header_bits_nxt    = in_ch.data_byte[6:0];
            header_pending_nxt = 1'b0;
          end
          if (in_ch.data_byte != h264nal_pkg::BYTE_ZERO) begin
            payload_seen_nxt = 1'b1;
          end
        end
        if (in_ch.data_byte == h264nal_pkg::BYTE_ZERO) begin
          if (zero_run_r != CNT_MAX) begin
            zero_run_nxt = zero_run_r + CNT_ONE;
          end
        end else begin
          zero_run_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_count_r     <= '0;
      zero_run_r       <= '0;
      start_seen_r     <= 1'b0;
      header_pending_r <= 1'b0;
      header_bits_r    <= '0;
      payload_seen_r   <= 1'b0;
      overflow_r       <= 1'b0;
    end else begin
      unit_count_r     <= unit_count_nxt;
      zero_run_r       <= zero_run_nxt;
      start_seen_r     <= start_seen_nxt;
      header_pending_r <= header_pending_nxt;
      header_bits_r    <= header_bits_nxt;
      payload_seen_r   <= payload_seen_nxt;
      overflow_r       <= overflow_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/h264nal_fifo.sv
// Small register FIFO that decouples the scanner from the result formatter.
`timescale 1ns / 1ps
`default_nettype none

module h264nal_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = h264nal_pkg::FIFO_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      head_data,
  output logic                  full,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head_data = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/h264nal_back.sv
// Result formatter: turns a unit snapshot into the output descriptor register.
`timescale 1ns / 1ps
`default_nettype none

module h264nal_back #(
  parameter int SIZE_BITS = h264nal_pkg::SIZE_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     fifo_empty,
  input  wire h264nal_pkg::unit_info_t  head_info,
  input  wire logic [SIZE_BITS-1:0]     head_count,
  input  wire logic [SIZE_BITS-1:0]     head_zeros,
  output logic                          pop,
  h264nal_out_if.source                 out_ch
);

  localparam int OW = h264nal_pkg::OUT_SIZE_BITS;
  localparam int WB = (SIZE_BITS > OW) ? SIZE_BITS : OW;
  localparam logic [WB-1:0] OUT_MAX_W = WB'({OW{1'b1}});
  localparam logic [OW-1:0] OUT_MAX = '1;

  logic                 out_valid_r, out_valid_nxt;
  logic [OW-1:0]        unit_size_r;
  logic [4:0]           nal_type_r;
  logic [1:0]           ref_level_r;
  logic                 type_invalid_r;
  logic [1:0]           status_r;
  logic                 size_saturated_r;

  logic [SIZE_BITS-1:0] diff;
  logic [WB-1:0]        diff_w;
  logic                 too_big;
  logic [OW-1:0]        size_c;
  logic [4:0]           type_c;
  logic [1:0]           ref_c;
  logic                 invalid_c;
  logic [1:0]           status_c;
  logic                 sat_c;

  assign pop = !fifo_empty && (!out_valid_r || out_ch.ready);

  always_comb begin
    diff    = (head_count >= head_zeros) ? head_count - head_zeros : '0;
    diff_w  = WB'(diff);
    too_big = diff_w > OUT_MAX_W;
    type_c  = head_info.header_bits[4:0];
    ref_c   = head_info.header_bits[6:5];
    if (type_c inside {h264nal_pkg::TYPE_IDR, h264nal_pkg::TYPE_SPS,
                       h264nal_pkg::TYPE_PPS}) begin
      ref_c = h264nal_pkg::REF_FORCED;
    end
    invalid_c = (type_c == h264nal_pkg::TYPE_NONE);
    if (head_info.overflow || too_big) begin
      size_c = OUT_MAX;
      sat_c  = 1'b1;
    end else begin
      size_c = diff_w[OW-1:0];
      sat_c  = 1'b0;
    end
    if (!head_info.payload_seen) begin
      status_c = h264nal_pkg::STATUS_ERR;
    end else if (head_info.last) begin
      status_c = h264nal_pkg::STATUS_LAST;
    end else begin
      status_c = h264nal_pkg::STATUS_OK;
    end
    if (head_info.no_start) begin
      size_c    = '0;
      type_c    = '0;
      ref_c     = '0;
      invalid_c = 1'b0;
      status_c  = h264nal_pkg::STATUS_ERR;
      sat_c     = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      unit_size_r      <= size_c;
      nal_type_r       <= type_c;
      ref_level_r      <= ref_c;
      type_invalid_r   <= invalid_c;
      status_r         <= status_c;
      size_saturated_r <= sat_c;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.unit_size      = unit_size_r;
  assign out_ch.nal_type       = nal_type_r;
  assign out_ch.ref_level      = ref_level_r;
  assign out_ch.type_invalid   = type_invalid_r;
  assign out_ch.status         = status_r;
  assign out_ch.size_saturated = size_saturated_r;

endmodule

`default_nettype wire

>>> rtl/core/h264nal_splitter_top.sv
// Top level of the H.264 Annex B start-code splitter.
`timescale 1ns / 1ps
`default_nettype none

// Takes one Annex B stream byte per cycle (kind 0) and an end-of-stream marker
// (kind 1), and emits one descriptor per finished unit: its size including its
// start code, its type, its reference level, a zero-type flag and a status.
// One byte per clock is sustained while the unit queue is not full. The byte
// or marker that closes a unit writes its snapshot into that queue, which in
// turn feeds the output register. A four-entry queue between the scanner and
// the output register absorbs output stalls, and input ready drops only when
// that queue is full. After end of stream the scanner returns to its reset state.
module h264_annexb_nal_splitter_top #(
  parameter int SIZE_BITS = h264nal_pkg::SIZE_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  h264nal_in_if.sink     in_ch,
  h264nal_out_if.source  out_ch
);

  localparam int QW = h264nal_pkg::INFO_W + 2 * SIZE_BITS;

  logic                     push;
  h264nal_pkg::unit_info_t  push_info;
  logic [SIZE_BITS-1:0]     push_count;
  logic [SIZE_BITS-1:0]     push_zeros;
  logic                     pop;
  logic                     fifo_full;
  logic                     fifo_empty;
  logic [QW-1:0]            head_data;
  h264nal_pkg::unit_info_t  head_info;

  assign head_info = h264nal_pkg::unit_info_t'(head_data[QW-1 -: h264nal_pkg::INFO_W]);

  h264nal_front #(
    .SIZE_BITS (SIZE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .fifo_full  (fifo_full),
    .push       (push),
    .push_info  (push_info),
    .push_count (push_count),
    .push_zeros (push_zeros)
  );

  h264nal_fifo #(
    .WIDTH (QW),
    .DEPTH (h264nal_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_info, push_count, push_zeros}),
    .pop       (pop),
    .head_data (head_data),
    .full      (fifo_full),
    .empty     (fifo_empty)
  );

  h264nal_back #(
    .SIZE_BITS (SIZE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (fifo_empty),
    .head_info  (head_info),
    .head_count (head_data[2*SIZE_BITS-1:SIZE_BITS]),
    .head_zeros (head_data[SIZE_BITS-1:0]),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire
